>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, muted while reset is high.
`define DGRC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define DGRC_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/dgrc_pkg.sv
// ----------------------------------------------------------------------------
// dgrc_pkg
// Types, constants and fixed-point helpers of the diagonal gated RNN cell.
// ----------------------------------------------------------------------------
package dgrc_pkg;

  localparam int DATA_WIDTH  = 16;
  localparam int FRAC_BITS   = 12;
  localparam int GATE_WIDTH  = FRAC_BITS + 1;       // 0 .. ONE
  localparam int CAND_WIDTH  = FRAC_BITS + 2;       // -ONE .. ONE, signed
  localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 2;
  localparam int BLEND_WIDTH = DATA_WIDTH + GATE_WIDTH + 1;
  localparam int ABS_WIDTH   = DATA_WIDTH + 2;      // holds 2*|z|
  localparam int Y32_WIDTH   = FRAC_BITS + 7;       // holds 32*ONE plus rounding

  localparam int ONE = 1 << FRAC_BITS;

  localparam logic [Y32_WIDTH-1:0] Y32_ONE = Y32_WIDTH'(32 * ONE);

  localparam logic signed [SUM_WIDTH-1:0] SAT_HI = SUM_WIDTH'((1 << (DATA_WIDTH - 1)) - 1);
  localparam logic signed [SUM_WIDTH-1:0] SAT_LO = SUM_WIDTH'(-(1 << (DATA_WIDTH - 1)));
  localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF = SUM_WIDTH'(1 << (FRAC_BITS - 1));

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    data_t hidden_prev;
    data_t input_value;
    data_t gate_projection;
    data_t hidden_weight;
    data_t input_weight;
    data_t gate_weight;
    data_t candidate_bias;
    data_t gate_bias;
  } src_req_t;

  typedef struct packed {
    data_t                 hidden_next;
    data_t                 candidate_preact;
    logic [GATE_WIDTH-1:0] gate_value;
  } dst_req_t;

  // Round to FRAC_BITS fraction bits: add half, floor.
  function automatic logic signed [SUM_WIDTH-1:0] round_fx(
    input logic signed [SUM_WIDTH-1:0] v
  );
    return (v + ROUND_HALF) >>> FRAC_BITS;
  endfunction

  function automatic data_t sat_data(input logic signed [SUM_WIDTH-1:0] v);
    data_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[DATA_WIDTH-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DATA_WIDTH-1:0];
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  // 32 * piecewise-linear sigmoid of a non-negative argument.
  function automatic logic [Y32_WIDTH-1:0] plan32(input logic [ABS_WIDTH-1:0] a);
    logic [ABS_WIDTH+2:0] a8;
    logic [Y32_WIDTH-1:0] y;
    a8 = {a, 3'b000};
    if (a >= ABS_WIDTH'(5 * ONE)) begin
      y = Y32_ONE;
    end else if (a8 >= (ABS_WIDTH + 3)'(19 * ONE)) begin
      y = Y32_WIDTH'(a) + Y32_WIDTH'(27 * ONE);
    end else if (a >= ABS_WIDTH'(ONE)) begin
      y = Y32_WIDTH'({a, 2'b00}) + Y32_WIDTH'(20 * ONE);
    end else begin
      y = Y32_WIDTH'(a8) + Y32_WIDTH'(16 * ONE);
    end
    return y;
  endfunction

  function automatic logic [ABS_WIDTH-1:0] abs_data(input data_t z);
    logic signed [ABS_WIDTH-1:0] zx;
    zx = ABS_WIDTH'(z);
    return zx[ABS_WIDTH-1] ? ABS_WIDTH'(-zx) : ABS_WIDTH'(zx);
  endfunction

endpackage

>>> design/dgrc_act.sv
// ----------------------------------------------------------------------------
// dgrc_act
// Piecewise-linear sigmoid for the gate and tanh for the candidate.
// ----------------------------------------------------------------------------
module dgrc_act (
  input  dgrc_pkg::data_t                        gate_z,
  input  dgrc_pkg::data_t                        preact,
  output logic [dgrc_pkg::GATE_WIDTH-1:0]        gate_value,
  output logic signed [dgrc_pkg::CAND_WIDTH-1:0] candidate
);

  logic [dgrc_pkg::ABS_WIDTH-1:0] gate_abs;
  logic [dgrc_pkg::ABS_WIDTH-1:0] cand_abs;
  logic [dgrc_pkg::ABS_WIDTH-1:0] cand_abs2;
  logic [dgrc_pkg::Y32_WIDTH-1:0] gate_y32;
  logic [dgrc_pkg::Y32_WIDTH-1:0] gate_y32_signed;
  logic [dgrc_pkg::Y32_WIDTH-1:0] gate_rnd;
  logic [dgrc_pkg::Y32_WIDTH-1:0] cand_y32;
  logic [dgrc_pkg::Y32_WIDTH:0]   cand_t32;
  logic [dgrc_pkg::Y32_WIDTH:0]   cand_rnd;
  logic [dgrc_pkg::CAND_WIDTH-1:0] cand_mag;

  // sigmoid: mirror around one half for negative input
  assign gate_abs        = dgrc_pkg::abs_data(gate_z);
  assign gate_y32        = dgrc_pkg::plan32(gate_abs);
  assign gate_y32_signed = gate_z[dgrc_pkg::DATA_WIDTH-1] ? (dgrc_pkg::Y32_ONE - gate_y32)
                                                          : gate_y32;
  assign gate_rnd        = gate_y32_signed + dgrc_pkg::Y32_WIDTH'(16);
  assign gate_value      = dgrc_pkg::GATE_WIDTH'(gate_rnd >> 5);

  // tanh(z) = 2*sigmoid(2|z|) - 1, sign restored afterwards
  assign cand_abs  = dgrc_pkg::abs_data(preact);
  assign cand_abs2 = {cand_abs[dgrc_pkg::ABS_WIDTH-2:0], 1'b0};
  assign cand_y32  = dgrc_pkg::plan32(cand_abs2);
  assign cand_t32  = {cand_y32, 1'b0} - {1'b0, dgrc_pkg::Y32_ONE};
  assign cand_rnd  = cand_t32 + (dgrc_pkg::Y32_WIDTH + 1)'(16);
  assign cand_mag  = dgrc_pkg::CAND_WIDTH'(cand_rnd >> 5);
  assign candidate = preact[dgrc_pkg::DATA_WIDTH-1] ? -$signed(cand_mag) : $signed(cand_mag);

endmodule

>>> design/diagonal_gated_rnn_cell_forward_unit.sv
// ----------------------------------------------------------------------------
// diagonal_gated_rnn_cell_forward_unit
// Forward step of a diagonal gated recurrent cell, one hidden element per request.
// ----------------------------------------------------------------------------
// Usage
//   src channel: one request per hidden element, carrying h, x, the gate
//   projection and the element's diagonal weights and biases. A request is
//   taken on a rising edge with src_valid high and src_stall low.
//   dst channel: one response per request, in order: the blended hidden
//   value, the saturated candidate pre-activation and the gate (0..4096).
// Timing
//   Five register stages: products, rounded sums, activations, blend
//   products, rounded and saturated output. Throughput is one request per
//   cycle while dst_stall is low, set by the fully pipelined multipliers of
//   stages one and four.
// Stall
//   Each stage loads when it is empty or the stage after it moves, so
//   bubbles are squeezed out. A held dst_stall freezes the output register
//   and backs up the pipe; src_stall rises only when all five stages are full.
// Reset
//   rst (synchronous, active high) clears the stage valid bits; no state is
//   kept between requests, so nothing else needs clearing.
// ----------------------------------------------------------------------------
module diagonal_gated_rnn_cell_forward_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  dgrc_pkg::src_req_t src_data,
  output logic               dst_valid,
  input  logic               dst_stall,
  output dgrc_pkg::dst_req_t dst_data
);

  localparam int STAGES = 5;

  // valid bit and advance enable per stage (index 0 is stage one)
  logic [STAGES-1:0] stage_valid;
  logic [STAGES-1:0] stage_adv;

  always_comb begin
    stage_adv[STAGES-1] = !stage_valid[STAGES-1] || !dst_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      stage_adv[i] = !stage_valid[i] || stage_adv[i+1];
    end
  end

  assign src_stall = !stage_adv[0];
  assign dst_valid = stage_valid[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_adv[0]) begin
        stage_valid[0] <= src_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (stage_adv[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  // ---- stage 1: the three weight products, exact ----
  logic signed [dgrc_pkg::PROD_WIDTH-1:0] s1_hw_prod;
  logic signed [dgrc_pkg::PROD_WIDTH-1:0] s1_xw_prod;
  logic signed [dgrc_pkg::PROD_WIDTH-1:0] s1_gw_prod;
  dgrc_pkg::data_t s1_h;
  dgrc_pkg::data_t s1_proj;
  dgrc_pkg::data_t s1_cbias;
  dgrc_pkg::data_t s1_gbias;

  always_ff @(posedge clk) begin
    if (stage_adv[0]) begin
      s1_hw_prod <= dgrc_pkg::PROD_WIDTH'(src_data.hidden_weight) *
                    dgrc_pkg::PROD_WIDTH'(src_data.hidden_prev);
      s1_xw_prod <= dgrc_pkg::PROD_WIDTH'(src_data.input_weight) *
                    dgrc_pkg::PROD_WIDTH'(src_data.input_value);
      s1_gw_prod <= dgrc_pkg::PROD_WIDTH'(src_data.gate_weight) *
                    dgrc_pkg::PROD_WIDTH'(src_data.hidden_prev);
      s1_h       <= src_data.hidden_prev;
      s1_proj    <= src_data.gate_projection;
      s1_cbias   <= src_data.candidate_bias;
      s1_gbias   <= src_data.gate_bias;
    end
  end

  // ---- stage 2: round each product, add the terms, saturate ----
  logic signed [dgrc_pkg::SUM_WIDTH-1:0] preact_sum;
  logic signed [dgrc_pkg::SUM_WIDTH-1:0] gate_sum;
  dgrc_pkg::data_t s2_preact;
  dgrc_pkg::data_t s2_gate_z;
  dgrc_pkg::data_t s2_h;

  assign preact_sum = dgrc_pkg::round_fx(dgrc_pkg::SUM_WIDTH'(s1_hw_prod)) +
                      dgrc_pkg::round_fx(dgrc_pkg::SUM_WIDTH'(s1_xw_prod)) +
                      dgrc_pkg::SUM_WIDTH'(s1_cbias);
  assign gate_sum   = dgrc_pkg::round_fx(dgrc_pkg::SUM_WIDTH'(s1_gw_prod)) +
                      dgrc_pkg::SUM_WIDTH'(s1_proj) +
                      dgrc_pkg::SUM_WIDTH'(s1_gbias);

  always_ff @(posedge clk) begin
    if (stage_adv[1]) begin
      s2_preact <= dgrc_pkg::sat_data(preact_sum);
      s2_gate_z <= dgrc_pkg::sat_data(gate_sum);
      s2_h      <= s1_h;
    end
  end

  // ---- stage 3: sigmoid and tanh ----
  logic [dgrc_pkg::GATE_WIDTH-1:0]        act_gate;
  logic signed [dgrc_pkg::CAND_WIDTH-1:0] act_cand;
  logic [dgrc_pkg::GATE_WIDTH-1:0]        s3_gate;
  logic signed [dgrc_pkg::CAND_WIDTH-1:0] s3_cand;
  dgrc_pkg::data_t s3_preact;
  dgrc_pkg::data_t s3_h;

  dgrc_act u_act (
    .gate_z     (s2_gate_z),
    .preact     (s2_preact),
    .gate_value (act_gate),
    .candidate  (act_cand)
  );

  always_ff @(posedge clk) begin
    if (stage_adv[2]) begin
      s3_gate   <= act_gate;
      s3_cand   <= act_cand;
      s3_preact <= s2_preact;
      s3_h      <= s2_h;
    end
  end

  // ---- stage 4: blend products (1-g)*h and g*c ----
  logic [dgrc_pkg::GATE_WIDTH-1:0]         keep_gate;
  logic signed [dgrc_pkg::BLEND_WIDTH-1:0] keep_op;
  logic signed [dgrc_pkg::BLEND_WIDTH-1:0] gate_op;
  logic signed [dgrc_pkg::BLEND_WIDTH-1:0] s4_keep_prod;
  logic signed [dgrc_pkg::BLEND_WIDTH-1:0] s4_cand_prod;
  logic [dgrc_pkg::GATE_WIDTH-1:0]         s4_gate;
  dgrc_pkg::data_t s4_preact;

  assign keep_gate = dgrc_pkg::GATE_WIDTH'(dgrc_pkg::ONE) - s3_gate;
  assign keep_op   = dgrc_pkg::BLEND_WIDTH'({1'b0, keep_gate});
  assign gate_op   = dgrc_pkg::BLEND_WIDTH'({1'b0, s3_gate});

  always_ff @(posedge clk) begin
    if (stage_adv[3]) begin
      s4_keep_prod <= keep_op * dgrc_pkg::BLEND_WIDTH'(s3_h);
      s4_cand_prod <= gate_op * dgrc_pkg::BLEND_WIDTH'(s3_cand);
      s4_gate      <= s3_gate;
      s4_preact    <= s3_preact;
    end
  end

  // ---- stage 5: add, round, saturate into the output register ----
  logic signed [dgrc_pkg::SUM_WIDTH-1:0] blend_sum;

  assign blend_sum = dgrc_pkg::SUM_WIDTH'(s4_keep_prod) + dgrc_pkg::SUM_WIDTH'(s4_cand_prod);

  always_ff @(posedge clk) begin
    if (stage_adv[4]) begin
      dst_data.hidden_next      <= dgrc_pkg::sat_data(dgrc_pkg::round_fx(blend_sum));
      dst_data.candidate_preact <= s4_preact;
      dst_data.gate_value       <= s4_gate;
    end
  end

endmodule

>>> design/dgrc_checker.sv
// ----------------------------------------------------------------------------
// dgrc_checker
// Port-level checks on the diagonal gated RNN cell, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dgrc_checker (
  input logic               clk,
  input logic               rst,
  input logic               src_valid,
  input logic               src_stall,
  input dgrc_pkg::src_req_t src_data,
  input logic               dst_valid,
  input logic               dst_stall,
  input dgrc_pkg::dst_req_t dst_data
);

  `DGRC_ASSERT(a_dst_hold, clk, rst, dst_valid && dst_stall |=> dst_valid && $stable(dst_data), "stalled response changed")

  `DGRC_ASSERT(a_gate_range, clk, rst, dst_valid |-> dst_data.gate_value <= dgrc_pkg::GATE_WIDTH'(dgrc_pkg::ONE), "gate above one")

  `DGRC_ASSERT(a_no_false_stall, clk, rst, !dst_valid |-> !src_stall, "request stalled with empty output")

  `DGRC_ASSERT_RST(a_reset_empty, clk, rst |=> !dst_valid, "response valid right after reset")

endmodule

bind diagonal_gated_rnn_cell_forward_unit dgrc_checker u_dgrc_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .src_data  (src_data),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_data  (dst_data)
);

>>> tb/tb_diagonal_gated_rnn_cell_forward_unit.sv
// ----------------------------------------------------------------------------
// tb_diagonal_gated_rnn_cell_forward_unit
// Self-checking bench for the diagonal gated RNN cell forward step. Requests
// go in through the src channel in random bursts. Responses are taken from the
// dst channel under a changing stall pattern and compared field by field
// against an in-bench fixed-point model of the cell.
// ----------------------------------------------------------------------------
module tb_diagonal_gated_rnn_cell_forward_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import dgrc_pkg::*;

  // ---- run shape ------------------------------------------------------------
  localparam int unsigned RANDOM_REQUESTS = 2000;
  localparam int unsigned STUCK_LIMIT     = 1000;  // cycles with no handshake at all
  localparam int unsigned HOLD_OFF_CYCLES = 48;    // long dst stall, fills the pipe
  localparam int unsigned DRAIN_CYCLES    = 12;    // pipe is five deep

  // ---- fixed-point constants for the cell model -----------------------------
  localparam longint ONE_L    = 64'sd1 << FRAC_BITS;
  localparam longint HALF_LSB = 64'sd1 << (FRAC_BITS - 1);
  localparam longint DATA_MAX = (64'sd1 << (DATA_WIDTH - 1)) - 1;
  localparam longint DATA_MIN = -(64'sd1 << (DATA_WIDTH - 1));

  // receiver stall behavior for one segment
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  logic     clk;
  logic     rst       = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_stall;
  src_req_t src_data  = '0;
  logic     dst_valid;
  logic     dst_stall = 1'b0;
  dst_req_t dst_data;

  diagonal_gated_rnn_cell_forward_unit dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---- cell model -----------------------------------------------------------
  // Everything is carried in 64-bit signed integers so products and sums are
  // exact; >>> on a signed longint is a floor divide by a power of two.

  function automatic longint clamp_data(longint v);
    return (v > DATA_MAX) ? DATA_MAX : ((v < DATA_MIN) ? DATA_MIN : v);
  endfunction

  // add half an LSB, then floor to FRAC_BITS fraction bits
  function automatic longint round_frac(longint v);
    return (v + HALF_LSB) >>> FRAC_BITS;
  endfunction

  // 32 * piecewise-linear sigmoid for a >= 0 (segments at 1, 2.375 and 5)
  function automatic longint pwl_sigmoid_x32(longint a);
    if (a >= 5 * ONE_L) begin
      return 32 * ONE_L;
    end else if (8 * a >= 19 * ONE_L) begin
      return a + 27 * ONE_L;
    end else if (a >= ONE_L) begin
      return 4 * a + 20 * ONE_L;
    end
    return 8 * a + 16 * ONE_L;
  endfunction

  function automatic longint gate_sigmoid(longint z);
    longint y32;
    y32 = pwl_sigmoid_x32((z < 0) ? -z : z);
    if (z < 0) begin
      y32 = 32 * ONE_L - y32;
    end
    return (y32 + 16) >>> 5;
  endfunction

  // tanh(z) = 2*sigmoid(2z) - 1, mirrored for negative z
  function automatic longint cand_tanh(longint z);
    longint mag;
    longint t;
    mag = (z < 0) ? -z : z;
    t   = ((2 * pwl_sigmoid_x32(2 * mag) - 32 * ONE_L) + 16) >>> 5;
    return (z < 0) ? -t : t;
  endfunction

  function automatic dst_req_t predict_cell_step(src_req_t rq);
    longint   h, x, p, wh, wx, wg, b, bg;
    longint   preact, gate_in, gate, cand, blend;
    dst_req_t r;
    h  = longint'($signed(rq.hidden_prev));
    x  = longint'($signed(rq.input_value));
    p  = longint'($signed(rq.gate_projection));
    wh = longint'($signed(rq.hidden_weight));
    wx = longint'($signed(rq.input_weight));
    wg = longint'($signed(rq.gate_weight));
    b  = longint'($signed(rq.candidate_bias));
    bg = longint'($signed(rq.gate_bias));
    preact  = clamp_data(round_frac(wh * h) + round_frac(wx * x) + b);
    gate_in = clamp_data(round_frac(wg * h) + p + bg);
    gate    = gate_sigmoid(gate_in);
    cand    = cand_tanh(preact);
    blend   = clamp_data(round_frac((ONE_L - gate) * h + gate * cand));
    r.hidden_next      = data_t'(blend);
    r.candidate_preact = data_t'(preact);
    r.gate_value       = GATE_WIDTH'(gate);
    return r;
  endfunction

  // ---- scoreboard -----------------------------------------------------------
  class cell_result_tracker;
    dst_req_t    expected_q[$];
    int unsigned failures;
    int unsigned checked;

    function void note_request(src_req_t rq);
      expected_q.push_back(predict_cell_step(rq));
    endfunction

    function void check_response(dst_req_t got);
      dst_req_t want;
      if (expected_q.size() == 0) begin
        failures++;
        $error("response with no request outstanding: hidden_next %0d", got.hidden_next);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.hidden_next !== want.hidden_next) begin
        failures++;
        $error("hidden_next: expected %0d, got %0d", want.hidden_next, got.hidden_next);
      end
      if (got.candidate_preact !== want.candidate_preact) begin
        failures++;
        $error("candidate_preact: expected %0d, got %0d",
               want.candidate_preact, got.candidate_preact);
      end
      if (got.gate_value !== want.gate_value) begin
        failures++;
        $error("gate_value: expected %0d, got %0d", want.gate_value, got.gate_value);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  cell_result_tracker tracker = new();

  int unsigned sent_count     = 0;
  int unsigned directed_count = 0;
  int unsigned hold_offs      = 0;
  int unsigned drain_pauses   = 0;
  int unsigned stuck_cycles   = 0;
  bit          hold_off_req   = 1'b0;

  // ---- monitor and watchdog -------------------------------------------------
  // Both handshakes are sampled at the rising edge; the bench only changes
  // inputs at the falling edge, so values seen here are settled.
  always @(posedge clk) begin
    if (!rst) begin
      if (src_valid && !src_stall) begin
        tracker.note_request(src_data);
      end
      if (dst_valid && !dst_stall) begin
        tracker.check_response(dst_data);
      end
      if ((src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
        stuck_cycles = 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                 STUCK_LIMIT, tracker.pending());
        $display("tb_diagonal_gated_rnn_cell_forward_unit: FAIL");
        $finish;
      end else begin
        stuck_cycles = stuck_cycles + 1;
      end
    end
  end

  // ---- receiver -------------------------------------------------------------
  // Works in segments of random length, each with its own stall mode. A long
  // hold-off requested by the sender side overrides the current segment.
  initial begin
    stall_mode_e stall_mode;
    int unsigned seg_left;
    int unsigned hold_left;
    int unsigned phase;
    stall_mode = STALL_NONE;
    seg_left   = 0;
    hold_left  = 0;
    phase      = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
        hold_offs++;
      end
      if (hold_left != 0) begin
        hold_left--;
        dst_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          seg_left   = $urandom_range(8, 60);
        end
        seg_left--;
        phase++;
        case (stall_mode)
          STALL_NONE: begin
            dst_stall <= 1'b0;
          end
          STALL_LIGHT: begin
            dst_stall <= ($urandom_range(0, 99) < 25);
          end
          STALL_PERIODIC: begin
            dst_stall <= (phase % 3 == 0);
          end
          default: begin
            dst_stall <= ($urandom_range(0, 99) < 70);
          end
        endcase
      end
    end
  end

  // ---- sender tasks ---------------------------------------------------------
  // Offer one request and hold it until the block takes it.
  task automatic send_request(input src_req_t rq);
    @(negedge clk);
    src_valid <= 1'b1;
    src_data  <= rq;
    do begin
      @(posedge clk);
    end while (src_stall);
    sent_count++;
  endtask

  task automatic pause_src(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      src_valid <= 1'b0;
    end
  endtask

  // stop sending until every outstanding response has been checked
  task automatic wait_for_drain();
    pause_src(1);
    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
    drain_pauses++;
  endtask

  task automatic send_fields(input data_t h, input data_t x, input data_t p,
                             input data_t wh, input data_t wx, input data_t wg,
                             input data_t b, input data_t bg);
    src_req_t rq;
    rq.hidden_prev     = h;
    rq.input_value     = x;
    rq.gate_projection = p;
    rq.hidden_weight   = wh;
    rq.input_weight    = wx;
    rq.gate_weight     = wg;
    rq.candidate_bias  = b;
    rq.gate_bias       = bg;
    send_request(rq);
    directed_count++;
  endtask

  // Drive the gate input through the projection and the candidate sum through
  // the candidate bias, weights zeroed, to land exactly on a segment edge.
  task automatic send_edges(input data_t gz, input data_t pre);
    send_fields(16'sd4096, 16'sd0, gz, 16'sd0, 16'sd0, 16'sd0, pre, 16'sd0);
  endtask

  // ---- random request generation --------------------------------------------
  function automatic data_t any_code();
    return data_t'($urandom);
  endfunction

  function automatic data_t near_zero(int unsigned span);
    return data_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  // Mostly moderate values (|x| up to a few units) so every sigmoid/tanh
  // segment is visited; a fifth are raw codes for saturation and bit coverage.
  function automatic src_req_t random_request();
    src_req_t rq;
    if ($urandom_range(0, 4) == 0) begin
      rq = {any_code(), any_code(), any_code(), any_code(),
            any_code(), any_code(), any_code(), any_code()};
    end else begin
      rq.hidden_prev     = near_zero(16384);
      rq.input_value     = near_zero(16384);
      rq.gate_projection = near_zero(16384);
      rq.hidden_weight   = near_zero(8192);
      rq.input_weight    = near_zero(8192);
      rq.gate_weight     = near_zero(8192);
      rq.candidate_bias  = near_zero(8192);
      rq.gate_bias       = near_zero(8192);
    end
    return rq;
  endfunction

  // ---- main sequence --------------------------------------------------------
  initial begin
    int unsigned burst;
    bit          hold_done;
    bit          drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes
    send_fields('0, '0, '0, '0, '0, '0, '0, '0);
    send_fields(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_fields(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_fields(16'sh7fff, 16'sh8000, 16'sh0000, 16'sh8000,
                16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh0000);
    // sigmoid segment edges at 5, 2.375 and 1.0, both signs; the candidate
    // sum sits on the matching tanh edges (2z hits the same points)
    send_edges(16'sd20480, 16'sd10240);
    send_edges(16'sd20479, 16'sd10239);
    send_edges(16'sd9728, 16'sd4864);
    send_edges(16'sd9727, 16'sd4863);
    send_edges(16'sd4096, 16'sd2048);
    send_edges(16'sd4095, 16'sd2047);
    send_edges(-16'sd20480, -16'sd10240);
    send_edges(-16'sd9728, -16'sd4864);
    send_edges(-16'sd4096, -16'sd2048);
    send_edges(-16'sd1, -16'sd1);
    // gate sum saturates high and low, gate fully open / fully closed
    send_fields(16'sh7fff, 16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7fff);
    send_fields(16'sh8000, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh8000);
    // candidate sum saturates through the products
    send_fields(16'sh8000, 16'sh8000, 16'sd0, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 16'sd0);
    send_fields(16'sh7fff, 16'sh8000, 16'sd0, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0);
    // product rounding on exact half LSB, both signs
    send_fields(16'sd2048, 16'sd2048, 16'sd0, 16'sd1, -16'sd1, 16'sd1, 16'sd0, 16'sd0);
    send_fields(-16'sd2048, 16'sd6144, 16'sd0, 16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'sd0);

    wait_for_drain();

    // random: bursts with gaps, plus one long output hold-off under a full
    // burst and one full drain partway through
    while (sent_count < directed_count + RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 40);
      if (!hold_done && sent_count >= 600) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
        burst        = 40;
      end
      if (!drain_done && sent_count >= 1200) begin
        wait_for_drain();
        drain_done = 1'b1;
      end
      repeat (burst) send_request(random_request());
      if ($urandom_range(0, 3) != 0) begin
        pause_src($urandom_range(1, 8));
      end
    end
    pause_src(1);

    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.pending() != 0) begin
      tracker.failures++;
      $error("%0d responses never arrived", tracker.pending());
    end

    $display("Covered %0d requests (%0d directed edge cases), %0d responses checked.",
             sent_count, directed_count, tracker.checked);
    $display("Output hold-offs: %0d, full drains: %0d, mismatches: %0d.",
             hold_offs, drain_pauses, tracker.failures);
    if (tracker.failures == 0) begin
      $display("tb_diagonal_gated_rnn_cell_forward_unit: PASS");
    end else begin
      $display("tb_diagonal_gated_rnn_cell_forward_unit: FAIL");
    end
    $finish;
  end

endmodule
